/* rtl/core/motor_command_packet_framer_top_assert.svh */
// Assertion macros for the framer RTL.
`ifndef MOTOR_COMMAND_PACKET_FRAMER_TOP_ASSERT_SVH
`define MOTOR_COMMAND_PACKET_FRAMER_TOP_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define MCPF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off during reset.
`define MCPF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/mcpf_pkg.sv */
`timescale 1ns / 1ps

package mcpf_pkg;

    // Field widths
    localparam int CMD_W   = 8;
    localparam int GAIN_W  = 9;
    localparam int ADDR_W  = 8;
    localparam int BYTE_W  = 8;
    localparam int SPEED_W = 7;
    localparam int CFG_W   = 9;
    localparam int CFG_IDX_W = 2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MOTOR_ADDR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_GAIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_GAIN = 2'd2;

    // Register reset values
    localparam logic [ADDR_W-1:0] MOTOR_ADDR_RST = 8'd128;
    localparam logic [GAIN_W-1:0] GAIN_RST       = 9'd256;

    // Speed ceiling after scaling
    localparam logic [SPEED_W-1:0] SPEED_MAX = 7'd127;

    // CRC-16 (poly 0x1021, init 0, MSB first)
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'h0000;

    // Byte positions within one packet
    localparam logic [2:0] POS_ADDR    = 3'd0;
    localparam logic [2:0] POS_DIR     = 3'd1;
    localparam logic [2:0] POS_SPEED   = 3'd2;
    localparam logic [2:0] POS_CRC_HI  = 3'd3;
    localparam logic [2:0] POS_CRC_LO  = 3'd4;
    localparam int BYTES_PER_PACKET    = 5;
    localparam logic [3:0] BYTE_LAST   = 4'd9;

    // Output port codes
    localparam logic PORT_RIGHT = 1'b0;
    localparam logic PORT_LEFT  = 1'b1;

    // Default depth of the job queue
    localparam int QUEUE_DEPTH_DEF = 2;

    // One classified command pair, ready for framing
    typedef struct packed {
        logic               right_dir;
        logic [SPEED_W-1:0] right_speed;
        logic               left_dir;
        logic [SPEED_W-1:0] left_speed;
    } job_t;

    // One byte folded into the CRC, one bit per step
    function automatic logic [15:0] crc_add(input logic [15:0] crc_in,
                                            input logic [BYTE_W-1:0] data);
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

/* rtl/core/motor_command_packet_framer_top.sv */
`timescale 1ns / 1ps

// Channel   Dir  Handshake             Payload
// s_axis    in   tvalid/tready         tdata: left_cmd, right_cmd
// m_axis    out  tvalid/tready         tdata: data_byte; tuser: port; tlast
// cfg       in   cfg_we                cfg_index, cfg_data
//
// Each command pair yields ten bytes: right packet, then left packet.
// Output runs one byte per cycle while m_axis_tready holds; the byte
// sequencer in the back end sets that rate.
// The front end scales both wheels combinationally, registers the job and parks it in a
// short queue, so new pairs are taken while bytes still drain.
// A held-off output stalls the back end, then the queue, then s_axis_tready.
// Reset is asynchronous; no clearing pass is needed after it.

module motor_command_packet_framer_top
    import mcpf_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [15:0]          s_axis_tdata,   // [7:0] left_cmd, [15:8] right_cmd
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [7:0]           m_axis_tdata,   // [7:0] data_byte
    output logic                 m_axis_tuser,   // [0] port
    output logic                 m_axis_tlast
);

    logic [ADDR_W-1:0] motor_addr_reg;
    logic [ADDR_W-1:0] motor_addr_next;
    logic [GAIN_W-1:0] left_gain_reg;
    logic [GAIN_W-1:0] left_gain_next;
    logic [GAIN_W-1:0] right_gain_reg;
    logic [GAIN_W-1:0] right_gain_next;

    logic front_valid;
    logic front_ready;
    job_t front_job;
    logic queue_valid;
    logic queue_ready;
    job_t queue_job;

    // Configuration registers
    always_comb begin
        motor_addr_next = motor_addr_reg;
        left_gain_next  = left_gain_reg;
        right_gain_next = right_gain_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                REG_MOTOR_ADDR: motor_addr_next = cfg_data[ADDR_W-1:0];
                REG_LEFT_GAIN:  left_gain_next  = cfg_data[GAIN_W-1:0];
                REG_RIGHT_GAIN: right_gain_next = cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            motor_addr_reg <= MOTOR_ADDR_RST;
            left_gain_reg  <= GAIN_RST;
            right_gain_reg <= GAIN_RST;
        end
        else begin
            motor_addr_reg <= motor_addr_next;
            left_gain_reg  <= left_gain_next;
            right_gain_reg <= right_gain_next;
        end
    end

    mcpf_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .left_gain     (left_gain_reg),
        .right_gain    (right_gain_reg),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .job_valid     (front_valid),
        .job_ready     (front_ready),
        .job           (front_job)
    );

    mcpf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_job    (front_job),
        .out_valid (queue_valid),
        .out_ready (queue_ready),
        .out_job   (queue_job)
    );

    mcpf_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .motor_addr    (motor_addr_reg),
        .job_valid     (queue_valid),
        .job_ready     (queue_ready),
        .job           (queue_job),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

/* rtl/core/mcpf_front.sv */
`timescale 1ns / 1ps

module mcpf_front
    import mcpf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [GAIN_W-1:0] left_gain,
    input  logic [GAIN_W-1:0] right_gain,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [15:0]       s_axis_tdata,   // [7:0] left_cmd, [15:8] right_cmd
    output logic              job_valid,
    input  logic              job_ready,
    output job_t              job
);

    logic        valid_reg;
    logic        valid_next;
    job_t        job_reg;
    job_t        job_next;
    logic        take;

    logic signed [CMD_W-1:0] left_cmd;
    logic signed [CMD_W-1:0] right_cmd;
    logic [CMD_W-1:0]        left_mag;
    logic [CMD_W-1:0]        right_mag;
    logic [CMD_W+GAIN_W-1:0] left_prod;
    logic [CMD_W+GAIN_W-1:0] right_prod;
    logic [GAIN_W-1:0]       left_scaled;
    logic [GAIN_W-1:0]       right_scaled;

    assign left_cmd  = s_axis_tdata[7:0];
    assign right_cmd = s_axis_tdata[15:8];

    // Stage is free when empty or when the queue takes its job
    assign s_axis_tready = !valid_reg || job_ready;
    assign take          = s_axis_tvalid && s_axis_tready;

    // Magnitude, gain product, saturation
    always_comb begin
        left_mag     = left_cmd[CMD_W-1]  ? CMD_W'(-left_cmd)  : CMD_W'(left_cmd);
        right_mag    = right_cmd[CMD_W-1] ? CMD_W'(-right_cmd) : CMD_W'(right_cmd);
        left_prod    = (CMD_W+GAIN_W)'(left_mag) * (CMD_W+GAIN_W)'(left_gain);
        right_prod   = (CMD_W+GAIN_W)'(right_mag) * (CMD_W+GAIN_W)'(right_gain);
        left_scaled  = left_prod[CMD_W+GAIN_W-1:8];
        right_scaled = right_prod[CMD_W+GAIN_W-1:8];

        job_next = job_reg;
        if (take) begin
            // right sends 1 going forward, left sends 1 in reverse
            job_next.right_dir   = !right_cmd[CMD_W-1];
            job_next.left_dir    = left_cmd[CMD_W-1];
            job_next.right_speed = (right_scaled > GAIN_W'(SPEED_MAX)) ?
                                   SPEED_MAX : right_scaled[SPEED_W-1:0];
            job_next.left_speed  = (left_scaled > GAIN_W'(SPEED_MAX)) ?
                                   SPEED_MAX : left_scaled[SPEED_W-1:0];
        end

        valid_next = valid_reg;
        if (take)
            valid_next = 1'b1;
        else if (job_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk) begin
        job_reg <= job_next;
    end

    assign job_valid = valid_reg;
    assign job       = job_reg;

endmodule

/* rtl/core/mcpf_queue.sv */
`timescale 1ns / 1ps

module mcpf_queue
    import mcpf_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  job_t in_job,
    output logic out_valid,
    input  logic out_ready,
    output job_t out_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_job   = entry_reg[rd_ptr_reg];

    // Pointer wrap and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk) begin
        if (push)
            entry_reg[wr_ptr_reg] <= in_job;
    end

endmodule

/* rtl/core/mcpf_back.sv */
`timescale 1ns / 1ps
`include "motor_command_packet_framer_top_assert.svh"

module mcpf_back
    import mcpf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [ADDR_W-1:0] motor_addr,
    input  logic              job_valid,
    output logic              job_ready,
    input  job_t              job,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [7:0]        m_axis_tdata,   // [7:0] data_byte
    output logic              m_axis_tuser,   // [0] port
    output logic              m_axis_tlast
);

    logic [3:0]        cnt_reg;
    logic [3:0]        cnt_next;
    logic [15:0]       crc_reg;
    logic [15:0]       crc_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [BYTE_W-1:0] out_byte_reg;
    logic [BYTE_W-1:0] out_byte_next;
    logic              out_port_reg;
    logic              out_port_next;
    logic              out_last_reg;
    logic              out_last_next;

    logic              advance;
    logic              is_left;
    logic [2:0]        pos;
    logic              dir;
    logic [SPEED_W-1:0] speed;
    logic [BYTE_W-1:0] cur_byte;

    // One byte per cycle while a job waits and the output slot frees up
    assign advance   = job_valid && (!out_valid_reg || m_axis_tready);
    assign job_ready = advance && (cnt_reg == BYTE_LAST);

    always_comb begin
        is_left  = (cnt_reg >= 4'(BYTES_PER_PACKET));
        pos      = is_left ? 3'(cnt_reg - 4'(BYTES_PER_PACKET)) : cnt_reg[2:0];
        dir      = is_left ? job.left_dir   : job.right_dir;
        speed    = is_left ? job.left_speed : job.right_speed;

        // Byte at this position, and the CRC as it runs
        crc_next = crc_reg;
        unique case (pos)
            POS_ADDR: begin
                cur_byte = motor_addr;
                crc_next = crc_add(CRC_INIT, cur_byte);
            end
            POS_DIR: begin
                cur_byte = {{(BYTE_W-1){1'b0}}, dir};
                crc_next = crc_add(crc_reg, cur_byte);
            end
            POS_SPEED: begin
                cur_byte = {1'b0, speed};
                crc_next = crc_add(crc_reg, cur_byte);
            end
            POS_CRC_HI: cur_byte = crc_reg[15:8];
            POS_CRC_LO: cur_byte = crc_reg[7:0];
            default:    cur_byte = '0;
        endcase

        cnt_next       = cnt_reg;
        out_byte_next  = out_byte_reg;
        out_port_next  = out_port_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg;
        if (advance) begin
            cnt_next       = (cnt_reg == BYTE_LAST) ? '0 : cnt_reg + 1'b1;
            out_byte_next  = cur_byte;
            out_port_next  = is_left ? PORT_LEFT : PORT_RIGHT;
            out_last_next  = (cnt_reg == BYTE_LAST);
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end
        if (!advance)
            crc_next = crc_reg;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else begin
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        crc_reg      <= crc_next;
        out_byte_reg <= out_byte_next;
        out_port_reg <= out_port_next;
        out_last_reg <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;
    assign m_axis_tuser  = out_port_reg;
    assign m_axis_tlast  = out_last_reg;

    // Checks
    `MCPF_ASSERT_NOW(a_cnt_range, clk, rst_n, 1'b1, cnt_reg <= BYTE_LAST,
        "byte counter out of range")
    `MCPF_ASSERT_NOW(a_last_on_left, clk, rst_n, out_valid_reg && out_last_reg,
        out_port_reg == PORT_LEFT, "last byte not on left port")
    `MCPF_ASSERT_NEXT(a_pop_wraps, clk, rst_n, job_ready,
        cnt_reg == '0 && out_last_reg && out_valid_reg, "job pop did not close run")

endmodule
